@@ rtl/rotated_point_projector_top_assert.svh @@
// Assertion macros for the rotated point projector top level.
`ifndef ROTATED_POINT_PROJECTOR_TOP_ASSERT_SVH
`define ROTATED_POINT_PROJECTOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RPP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rotated point projector check failed");

// next-cycle implication
`define RPP_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rotated point projector check failed");

`endif

@@ rtl/rpp_pkg.sv @@
// Shared types and constants of the rotated point projector.
package rpp_pkg;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ROW    = 2'd1,
    OP_POINT  = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_HINIT, ST_HDIV, ST_COL0, ST_COL1, ST_COL2,
    ST_D0, ST_D1, ST_L0, ST_L1, ST_DEN0, ST_DEN1, ST_NX0, ST_NX1,
    ST_XINIT, ST_XDIV, ST_XFIN, ST_NY, ST_YINIT, ST_YDIV, ST_YFIN,
    ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_HINIT, DP_DIV, DP_COL0, DP_COL1, DP_COL2,
    DP_D0, DP_D1, DP_L0, DP_L1, DP_DEN0, DP_DEN1, DP_NX0, DP_NX1,
    DP_XINIT, DP_XFIN, DP_NY, DP_YINIT, DP_YFIN
  } dp_op_e;

  typedef enum logic [2:0] {
    RES_SEG, RES_SYNC, RES_ROWCOL, RES_FILL, RES_WHITE
  } res_e;

  typedef struct packed {
    dp_op_e op;
    logic   out_load;
    res_e   kind;
  } cmd_t;

  typedef struct packed {
    logic d_ok;
    logic div_last;
    logic x_in;
    logic y_in;
  } sts_t;

  typedef struct packed {
    logic signed [15:0] sin_angle;
    logic signed [15:0] cos_angle;
    logic [19:0]        x_scale;
    logic [19:0]        y_scale;
    logic [15:0]        depth_scale;
    logic [31:0]        segment_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         remaining;
    logic [7:0]         duration;
    logic [23:0]        color_start;
    logic [23:0]        color_end;
    logic [1:0]         row_total;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } item_t;

  localparam logic [2:0] REG_SIN   = 3'd0;
  localparam logic [2:0] REG_COS   = 3'd1;
  localparam logic [2:0] REG_XSCL  = 3'd2;
  localparam logic [2:0] REG_YSCL  = 3'd3;
  localparam logic [2:0] REG_DSCL  = 3'd4;
  localparam logic [2:0] REG_SEG   = 3'd5;

  localparam logic [31:0] CMD_FILL  = 32'hF600_0000;
  localparam logic [31:0] CMD_PRIM  = 32'hFA00_0000;
  localparam logic [31:0] CMD_SYNC  = 32'hE700_0000;
  localparam logic [31:0] CMD_SEG   = 32'h0600_0000;
  localparam logic [31:0] WORD_WHITE = 32'hFFFF_FFFF;

  // -10.0 in Q.22
  localparam logic signed [40:0] DEPTH_LIMIT = -41'sd41943040;

  localparam logic [4:0] HDR_DIV_STEPS = 5'd24;
  localparam logic [4:0] PRJ_DIV_STEPS = 5'd10;

endpackage

@@ rtl/rpp_ctrl.sv @@
// Sequencing state machine of the rotated point projector.
module rpp_ctrl import rpp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  in_op_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  res_e   kind_q, kind_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= RES_SEG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_HEADER: state_d = ST_HINIT;
            OP_ROW: begin
              state_d = ST_EMIT;
              kind_d  = RES_SYNC;
            end
            OP_POINT: state_d = ST_D0;
            default: begin
              state_d = ST_EMIT;
              kind_d  = RES_WHITE;
            end
          endcase
        end
      end
      ST_HINIT: state_d = ST_HDIV;
      ST_HDIV:  if (sts_i.div_last) state_d = ST_COL0;
      ST_COL0:  state_d = ST_COL1;
      ST_COL1:  state_d = ST_COL2;
      ST_COL2: begin
        state_d = ST_EMIT;
        kind_d  = RES_SEG;
      end
      ST_D0:    state_d = ST_D1;
      ST_D1:    state_d = ST_L0;
      ST_L0:    state_d = ST_L1;
      ST_L1:    state_d = sts_i.d_ok ? ST_DEN0 : ST_IDLE;
      ST_DEN0:  state_d = ST_DEN1;
      ST_DEN1:  state_d = ST_NX0;
      ST_NX0:   state_d = ST_NX1;
      ST_NX1:   state_d = ST_XINIT;
      ST_XINIT: state_d = ST_XDIV;
      ST_XDIV:  if (sts_i.div_last) state_d = ST_XFIN;
      ST_XFIN:  state_d = sts_i.x_in ? ST_NY : ST_IDLE;
      ST_NY:    state_d = ST_YINIT;
      ST_YINIT: state_d = ST_YDIV;
      ST_YDIV:  if (sts_i.div_last) state_d = ST_YFIN;
      ST_YFIN: begin
        if (sts_i.y_in) begin
          state_d = ST_EMIT;
          kind_d  = RES_FILL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (kind_q == RES_SYNC) begin
            kind_d = RES_ROWCOL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = DP_NOP;
    cmd_o.out_load = 1'b0;
    cmd_o.kind     = kind_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      ST_HINIT: cmd_o.op = DP_HINIT;
      ST_HDIV:  cmd_o.op = DP_DIV;
      ST_COL0:  cmd_o.op = DP_COL0;
      ST_COL1:  cmd_o.op = DP_COL1;
      ST_COL2:  cmd_o.op = DP_COL2;
      ST_D0:    cmd_o.op = DP_D0;
      ST_D1:    cmd_o.op = DP_D1;
      ST_L0:    cmd_o.op = DP_L0;
      ST_L1:    cmd_o.op = DP_L1;
      ST_DEN0:  cmd_o.op = DP_DEN0;
      ST_DEN1:  cmd_o.op = DP_DEN1;
      ST_NX0:   cmd_o.op = DP_NX0;
      ST_NX1:   cmd_o.op = DP_NX1;
      ST_XINIT: cmd_o.op = DP_XINIT;
      ST_XDIV:  cmd_o.op = DP_DIV;
      ST_XFIN:  cmd_o.op = DP_XFIN;
      ST_NY:    cmd_o.op = DP_NY;
      ST_YINIT: cmd_o.op = DP_YINIT;
      ST_YDIV:  cmd_o.op = DP_DIV;
      ST_YFIN:  cmd_o.op = DP_YFIN;
      ST_EMIT:  cmd_o.out_load = out_free;
      default:  cmd_o.op = DP_NOP;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/rpp_datapath.sv @@
// Datapath: rotation MACs, shared multiplier, restoring divider, blend and output register.
module rpp_datapath import rpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  output sts_t        sts_o,
  output logic [31:0] word_high_o,
  output logic [31:0] word_low_o,
  output logic        last_o
);

  item_t              item_q;
  logic signed [40:0] d_q, d_d, l_q, l_d;
  logic [63:0]        acc_q, acc_d;
  logic [55:0]        den_q, den_d;
  logic [63:0]        rem_q, rem_d;
  logic [65:0]        dsr_q, dsr_d;
  logic [23:0]        q_q, q_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               ovf_q, ovf_d, neg_q, neg_d;
  logic [8:0]         x_q, x_d;
  logic [7:0]         y_q, y_d;
  logic [23:0]        blend_q, blend_d;
  logic [7:0]         astep_q, astep_d;
  logic [9:0]         asum_q, asum_d;
  logic [31:0]        hi_q, hi_d, lo_q, lo_d;
  logic               last_q, last_d;

  logic signed [23:0] sm_a;
  logic signed [15:0] sm_b;
  logic signed [39:0] sprod;
  logic [23:0]        um_a;
  logic [19:0]        um_b;
  logic [43:0]        uprod;
  logic [40:0]        d_neg, l_neg;
  logic [39:0]        dm, lm;
  logic [23:0]        pym;
  logic               ge;
  logic signed [10:0] qm, qs, xsum, ysum;
  logic [7:0]         ca, cb, chan;
  logic signed [8:0]  cdiff;
  logic signed [33:0] cprod;
  logic [7:0]         dur1, step_new;
  logic [2:0]         rows_k;
  logic [10:0]        asum_new;
  logic [20:0]        div3;
  logic [65:0]        xrem0, yrem0;
  logic [9:0]         xp1, yp1;

  assign d_neg = -d_q;
  assign l_neg = -l_q;
  assign dm    = d_neg[39:0];
  assign lm    = l_q[40] ? l_neg[39:0] : l_q[39:0];
  assign pym   = item_q.point_y[23] ? 24'(-item_q.point_y) : item_q.point_y;

  always_comb begin
    sm_a = item_q.point_z;
    sm_b = cfg_i.sin_angle;
    case (cmd_i.op)
      DP_D1: begin
        sm_a = item_q.point_x;
        sm_b = cfg_i.cos_angle;
      end
      DP_L0: begin
        sm_a = item_q.point_x;
        sm_b = cfg_i.sin_angle;
      end
      DP_L1: begin
        sm_a = item_q.point_z;
        sm_b = cfg_i.cos_angle;
      end
      default: begin
        sm_a = item_q.point_z;
        sm_b = cfg_i.sin_angle;
      end
    endcase
  end
  assign sprod = sm_a * sm_b;

  always_comb begin
    um_a = '0;
    um_b = '0;
    case (cmd_i.op)
      DP_DEN0: begin
        um_a = {4'b0, dm[19:0]};
        um_b = {4'b0, cfg_i.depth_scale};
      end
      DP_DEN1: begin
        um_a = {4'b0, dm[39:20]};
        um_b = {4'b0, cfg_i.depth_scale};
      end
      DP_NX0: begin
        um_a = {4'b0, lm[19:0]};
        um_b = cfg_i.x_scale;
      end
      DP_NX1: begin
        um_a = {4'b0, lm[39:20]};
        um_b = cfg_i.x_scale;
      end
      DP_NY: begin
        um_a = pym;
        um_b = cfg_i.y_scale;
      end
      default: begin
        um_a = '0;
        um_b = '0;
      end
    endcase
  end
  assign uprod = um_a * um_b;

  assign ge    = {2'b0, rem_q} >= dsr_q;
  assign xrem0 = {2'b0, acc_q[59:0], 4'b0};
  assign yrem0 = {2'b0, acc_q[45:0], 18'b0};

  assign qm   = $signed({1'b0, q_q[9:0]});
  assign qs   = neg_q ? -qm : qm;
  assign xsum = qs + 11'sd160;
  assign ysum = 11'sd120 - qs;

  always_comb begin
    case (cmd_i.op)
      DP_COL1: begin
        ca = item_q.color_start[15:8];
        cb = item_q.color_end[15:8];
      end
      DP_COL2: begin
        ca = item_q.color_start[23:16];
        cb = item_q.color_end[23:16];
      end
      default: begin
        ca = item_q.color_start[7:0];
        cb = item_q.color_end[7:0];
      end
    endcase
  end
  assign cdiff = $signed({1'b0, cb}) - $signed({1'b0, ca});
  assign cprod = cdiff * $signed({1'b0, q_q});
  assign chan  = ca + cprod[23:16];

  assign dur1     = (item_q.duration == 8'd0) ? 8'd1 : item_q.duration;
  assign step_new = (item_q.remaining >= 8'd64) ? 8'd255 : {item_q.remaining[5:0], 2'b0};
  assign rows_k   = 3'd4 - {1'b0, item_q.row_total};
  assign asum_new = step_new * rows_k;
  assign div3     = asum_q * 11'd683;

  assign xp1 = {1'b0, x_q} + 10'd1;
  assign yp1 = {2'b0, y_q} + 10'd1;

  always_comb begin
    d_d     = d_q;
    l_d     = l_q;
    acc_d   = acc_q;
    den_d   = den_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    q_d     = q_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    x_d     = x_q;
    y_d     = y_q;
    blend_d = blend_q;
    astep_d = astep_q;
    asum_d  = asum_q;
    case (cmd_i.op)
      DP_HINIT: begin
        rem_d   = {40'b0, item_q.remaining, 16'b0};
        dsr_d   = {35'b0, dur1, 23'b0};
        q_d     = '0;
        cnt_d   = HDR_DIV_STEPS;
        ovf_d   = 1'b0;
        astep_d = step_new;
        asum_d  = asum_new[9:0];
      end
      DP_DIV: begin
        if (ge) rem_d = rem_q - dsr_q[63:0];
        q_d   = {q_q[22:0], ge};
        dsr_d = dsr_q >> 1;
        cnt_d = cnt_q - 5'd1;
      end
      DP_COL0: blend_d[7:0]   = chan;
      DP_COL1: blend_d[15:8]  = chan;
      DP_COL2: blend_d[23:16] = chan;
      DP_D0:   d_d = 41'(sprod);
      DP_D1:   d_d = d_q - 41'(sprod);
      DP_L0:   l_d = 41'(sprod);
      DP_L1:   l_d = l_q + 41'(sprod);
      DP_DEN0: acc_d = 64'(uprod);
      DP_DEN1: den_d = acc_q[55:0] + 56'({uprod, 20'b0});
      DP_NX0:  acc_d = 64'(uprod);
      DP_NX1:  acc_d = acc_q + {uprod, 20'b0};
      DP_XINIT: begin
        rem_d = xrem0[63:0];
        dsr_d = {1'b0, den_q, 9'b0};
        ovf_d = xrem0 >= {den_q, 10'b0};
        neg_d = !l_q[40];
        q_d   = '0;
        cnt_d = PRJ_DIV_STEPS;
      end
      DP_XFIN: x_d = xsum[8:0];
      DP_NY:   acc_d = 64'(uprod);
      DP_YINIT: begin
        rem_d = yrem0[63:0];
        dsr_d = {1'b0, den_q, 9'b0};
        ovf_d = yrem0 >= {den_q, 10'b0};
        neg_d = !item_q.point_y[23];
        q_d   = '0;
        cnt_d = PRJ_DIV_STEPS;
      end
      DP_YFIN: y_d = ysum[7:0];
      default: ;
    endcase
    if (cmd_i.out_load && cmd_i.kind == RES_ROWCOL) begin
      asum_d = asum_q + {2'b0, astep_q};
    end
  end

  always_comb begin
    hi_d   = CMD_PRIM;
    lo_d   = WORD_WHITE;
    last_d = 1'b1;
    case (cmd_i.kind)
      RES_SEG: begin
        hi_d = CMD_SEG;
        lo_d = cfg_i.segment_address;
      end
      RES_SYNC: begin
        hi_d   = CMD_SYNC;
        lo_d   = '0;
        last_d = 1'b0;
      end
      RES_ROWCOL: begin
        hi_d = CMD_PRIM;
        lo_d = {blend_q, div3[18:11]};
      end
      RES_FILL: begin
        hi_d = CMD_FILL | {8'b0, xp1, 2'b0, yp1, 2'b0};
        lo_d = {8'b0, 1'b0, x_q, 2'b0, 2'b0, y_q, 2'b0};
      end
      default: begin
        hi_d = CMD_PRIM;
        lo_d = WORD_WHITE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      blend_q <= '0;
      astep_q <= '0;
      asum_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      blend_q <= blend_d;
      astep_q <= astep_d;
      asum_q  <= asum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) item_q <= item_i;
    d_q   <= d_d;
    l_q   <= l_d;
    acc_q <= acc_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    if (cmd_i.out_load) begin
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      last_q <= last_d;
    end
  end

  assign sts_o.d_ok     = (d_q < DEPTH_LIMIT) && (cfg_i.depth_scale != 16'd0);
  assign sts_o.div_last = cnt_q == 5'd1;
  assign sts_o.x_in     = !ovf_q && (qs >= -11'sd160) && (qs <= 11'sd159);
  assign sts_o.y_in     = !ovf_q && (qs >= -11'sd119) && (qs <= 11'sd120);

  assign word_high_o = hi_q;
  assign word_low_o  = lo_q;
  assign last_o      = last_q;

endmodule

@@ rtl/rotated_point_projector_top.sv @@
// Top level of the rotated point projector: APB registers, stream ports, controller and datapath.
//
// Takes one item at a time. A header runs a 24-step restoring division for the blend
// fraction and three blend multiplies; a row gives 2 beats, an end 1 beat. A visible point
// runs four rotation multiply-accumulates, five passes through the shared 24x20 multiplier
// and two 10-step restoring divisions, plus the fill beat; points behind the depth limit
// are dropped after the rotation steps. Results leave through an output register, so
// the next item is taken while the final beat of the previous one still waits.
module rotated_point_projector_top import rpp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // remaining, duration, color_start, color_end, row_total, point_x, point_y, point_z
  input  logic [143:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // word_high, word_low
  output logic [63:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  cfg_t  cfg_q;
  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  logic  cfg_wr;
  logic [2:0] reg_idx;
  logic [31:0] word_high, word_low;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_angle       <= 16'sd0;
      cfg_q.cos_angle       <= 16'sd16384;
      cfg_q.x_scale         <= 20'd40960;
      cfg_q.y_scale         <= 20'd30720;
      cfg_q.depth_scale     <= 16'd4096;
      cfg_q.segment_address <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SIN:  cfg_q.sin_angle       <= pwdata[15:0];
        REG_COS:  cfg_q.cos_angle       <= pwdata[15:0];
        REG_XSCL: cfg_q.x_scale         <= pwdata[19:0];
        REG_YSCL: cfg_q.y_scale         <= pwdata[19:0];
        REG_DSCL: cfg_q.depth_scale     <= pwdata[15:0];
        REG_SEG:  cfg_q.segment_address <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SIN:  prdata = {{16{cfg_q.sin_angle[15]}}, cfg_q.sin_angle};
      REG_COS:  prdata = {{16{cfg_q.cos_angle[15]}}, cfg_q.cos_angle};
      REG_XSCL: prdata = {12'b0, cfg_q.x_scale};
      REG_YSCL: prdata = {12'b0, cfg_q.y_scale};
      REG_DSCL: prdata = {16'b0, cfg_q.depth_scale};
      REG_SEG:  prdata = cfg_q.segment_address;
      default:  prdata = '0;
    endcase
  end

  assign item.remaining   = s_axis_tdata[7:0];
  assign item.duration    = s_axis_tdata[15:8];
  assign item.color_start = s_axis_tdata[39:16];
  assign item.color_end   = s_axis_tdata[63:40];
  assign item.row_total   = s_axis_tdata[65:64];
  assign item.point_x     = s_axis_tdata[89:66];
  assign item.point_y     = s_axis_tdata[113:90];
  assign item.point_z     = s_axis_tdata[137:114];

  rpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .sts_o       (sts),
    .word_high_o (word_high),
    .word_low_o  (word_low),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {word_low, word_high};

`include "rotated_point_projector_top_assert.svh"

  `RPP_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `RPP_ASSERT_NXT(a_row_pair_follows, m_axis_tvalid && !m_axis_tlast, m_axis_tvalid)
  `RPP_ASSERT_IMP(a_idle_out_final, s_axis_tready, !m_axis_tvalid || m_axis_tlast)

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the rotated point projector top level.
module tb import rpp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [31:0] word_high;
    logic [31:0] word_low;
    logic        last;
  } disp_cmd_t;

  logic         clk_i;
  logic         rst_ni;
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         s_axis_tvalid, s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  rotated_point_projector_top dut (.*);

  disp_cmd_t   cmd_q[$];
  cfg_t        view_cfg;
  logic [23:0] blend_color;
  logic [7:0]  alpha_step;
  logic [9:0]  alpha_sum;
  int          n_err;
  int          burst_left;
  int          idle_cnt;
  int          rdy_mode;
  int          rdy_cyc;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- prediction ----------------
  task automatic push_cmd(logic [31:0] hi, logic [31:0] lo, logic last);
    disp_cmd_t c;
    c.word_high = hi;
    c.word_low = lo;
    c.last = last;
    cmd_q.push_back(c);
  endtask

  task automatic predict_display(op_e op, item_t it);
    longint prog, a, b, cc, px, py, pz, s, co, d, lat, den, qx, qy, xs, ys, ds;
    logic [23:0] col;
    logic [8:0] dur;
    logic [9:0] ux, uy;
    col = '0;
    case (op)
      OP_HEADER: begin
        dur = (it.duration == 0) ? 9'd1 : {1'b0, it.duration};
        prog = longint'({it.remaining, 16'h0}) / longint'(dur);
        for (int sh = 0; sh <= 16; sh += 8) begin
          a = it.color_start[sh+:8];
          b = it.color_end[sh+:8];
          cc = a + (((b - a) * prog) >>> 16);
          col[sh+:8] = cc[7:0];
        end
        blend_color = col;
        alpha_step = (it.remaining >= 64) ? 8'd255 : it.remaining * 8'd4;
        alpha_sum = 10'(alpha_step * (3'd4 - it.row_total));
        push_cmd(CMD_SEG, view_cfg.segment_address, 1'b1);
      end
      OP_ROW: begin
        push_cmd(CMD_SYNC, 32'h0, 1'b0);
        push_cmd(CMD_PRIM, {blend_color, 8'(alpha_sum / 3)}, 1'b1);
        alpha_sum = alpha_sum + 10'(alpha_step);
      end
      OP_POINT: begin
        px = it.point_x;
        py = it.point_y;
        pz = it.point_z;
        s = view_cfg.sin_angle;
        co = view_cfg.cos_angle;
        xs = view_cfg.x_scale;
        ys = view_cfg.y_scale;
        ds = view_cfg.depth_scale;
        d = pz * s - px * co;
        lat = px * s + pz * co;
        if (d < -64'sd41943040 && ds != 0) begin
          den = d * ds;
          qx = (lat * xs * 16) / den;
          qy = (py * ys * 262144) / den;
          if (qx >= -160 && qx <= 159 && qy <= 120 && qy >= -119) begin
            ux = 10'(qx + 160);
            uy = 10'(120 - qy);
            push_cmd(CMD_FILL | (32'(ux + 10'd1) << 14) | (32'(uy + 10'd1) << 2),
                     (32'(ux) << 14) | (32'(uy) << 2), 1'b1);
          end
        end
      end
      default: push_cmd(CMD_PRIM, WORD_WHITE, 1'b1);
    endcase
  endtask

  // ---------------- drivers ----------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIN:  view_cfg.sin_angle = val[15:0];
      REG_COS:  view_cfg.cos_angle = val[15:0];
      REG_XSCL: view_cfg.x_scale = val[19:0];
      REG_YSCL: view_cfg.y_scale = val[19:0];
      REG_DSCL: view_cfg.depth_scale = val[15:0];
      default:  view_cfg.segment_address = val;
    endcase
  endtask

  task automatic send_item(op_e op, item_t it);
    logic rdy;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'b0, it.point_z, it.point_y, it.point_x, it.row_total,
                     it.color_end, it.color_start, it.duration, it.remaining};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    predict_display(op, it);
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for all commands, then for a possible silent point still in flight
  task automatic drain();
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_view(logic [15:0] s, logic [15:0] c, logic [19:0] xs,
                          logic [19:0] ys, logic [15:0] ds, logic [31:0] seg);
    drain();
    write_reg(REG_SIN, s);
    write_reg(REG_COS, c);
    write_reg(REG_XSCL, xs);
    write_reg(REG_YSCL, ys);
    write_reg(REG_DSCL, ds);
    write_reg(REG_SEG, seg);
  endtask

  // ---------------- item builders ----------------
  function automatic item_t noise_item();
    item_t it;
    logic [159:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = r[137:0];
    return it;
  endfunction

  function automatic item_t header_item(int rem, int dur, int cs, int ce, int rows);
    item_t it;
    it = noise_item();
    it.remaining = 8'(rem);
    it.duration = 8'(dur);
    it.color_start = 24'(cs);
    it.color_end = 24'(ce);
    it.row_total = 2'(rows);
    return it;
  endfunction

  function automatic item_t point_item(int x, int y, int z);
    item_t it;
    it = noise_item();
    it.point_x = 24'(x);
    it.point_y = 24'(y);
    it.point_z = 24'(z);
    return it;
  endfunction

  // point placed in front of the current view, mostly on screen
  function automatic item_t view_point();
    longint dq, lq, yq, s, c;
    dq = -longint'($urandom_range(2500, 1 << 20));
    lq = (dq * (longint'($urandom_range(0, 600)) - 300)) / 256;
    yq = (dq * (longint'($urandom_range(0, 600)) - 300)) / 256;
    s = view_cfg.sin_angle;
    c = view_cfg.cos_angle;
    return point_item(int'((lq * s - dq * c) >>> 14), int'(yq), int'((dq * s + lq * c) >>> 14));
  endfunction

  // ---------------- tests ----------------
  task automatic test_header_rows();
    send_item(OP_HEADER, header_item(0, 0, 24'h000000, 24'hFFFFFF, 0));
    send_item(OP_ROW, noise_item());
    send_item(OP_HEADER, header_item(255, 1, 24'hFFFFFF, 24'h000000, 3));
    send_item(OP_ROW, noise_item());
    send_item(OP_HEADER, header_item(64, 255, 24'h123456, 24'hFEDCBA, 1));
    send_item(OP_ROW, noise_item());
    send_item(OP_HEADER, header_item(63, 200, 24'hFF00FF, 24'h00FF00, 2));
    repeat (6) send_item(OP_ROW, noise_item());
    send_item(OP_END, noise_item());
  endtask

  task automatic test_points();
    send_item(OP_POINT, point_item(2560, 0, 0));
    send_item(OP_POINT, point_item(2561, 0, 0));
    send_item(OP_POINT, point_item(8388607, 8388607, 8388607));
    send_item(OP_POINT, point_item(8388607, -8388608, -8388608));
    send_item(OP_POINT, point_item(-8388608, 0, 0));
    send_item(OP_POINT, point_item(25600, 2560, -12800));
    send_item(OP_POINT, point_item(1000, 50000, 0));
    send_item(OP_END, noise_item());
  endtask

  task automatic test_random(int n_items);
    int sent, rows, pts;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(op_e'($urandom_range(0, 3)), noise_item());
        sent++;
      end else begin
        rows = $urandom_range(0, 3);
        send_item(OP_HEADER, header_item($urandom_range(0, 255),
                  $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 255),
                  $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF), rows));
        if ($urandom_range(0, 5) == 0) rows += $urandom_range(1, 4);
        repeat (rows) send_item(OP_ROW, noise_item());
        pts = $urandom_range(0, 12);
        repeat (pts) send_item(OP_POINT, view_point());
        send_item(OP_END, noise_item());
        sent += rows + pts + 2;
      end
    end
  endtask

  task automatic test_views();
    set_view(16'sd16384, 16'sd0, 20'hFFFFF, 20'd1, 16'd65535, 32'hFFFF_FFFF);
    test_random(350);
    set_view(-16'sd16384, 16'sd0, 20'd0, 20'hFFFFF, 16'd1, 32'h0);
    test_random(300);
    set_view(16'sd11585, -16'sd11585, 20'd40960, 20'd30720, 16'd0, $urandom());
    test_random(250);
    set_view(-16'sd11585, -16'sd16384, 20'd81920, 20'd15360, 16'd2048, $urandom());
    test_random(350);
    set_view(16'sd6270, 16'sd15137, 20'd40960, 20'd30720, 16'd4096, $urandom());
    test_random(400);
  endtask

  // ---------------- checking ----------------
  always @(negedge clk_i) begin
    disp_cmd_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cmd_q.size() == 0) begin
        $error("unexpected command beat %h last %b", m_axis_tdata, m_axis_tlast);
        n_err++;
      end else begin
        e = cmd_q.pop_front();
        if (m_axis_tdata[31:0] !== e.word_high) begin
          $error("word_high: expected %h actual %h", e.word_high, m_axis_tdata[31:0]);
          n_err++;
        end
        if (m_axis_tdata[63:32] !== e.word_low) begin
          $error("word_low: expected %h actual %h", e.word_low, m_axis_tdata[63:32]);
          n_err++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %b actual %b", e.last, m_axis_tlast);
          n_err++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    rdy_cyc <= rdy_cyc + 1;
    if (rdy_cyc % 300 == 0) rdy_mode <= $urandom_range(0, 2);
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    n_err = 0;
    burst_left = 0;
    idle_cnt = 0;
    rdy_mode = 0;
    rdy_cyc = 1;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_HEADER;
    m_axis_tready <= 1'b1;
    view_cfg = '{sin_angle: 16'sd0, cos_angle: 16'sd16384, x_scale: 20'd40960,
                 y_scale: 20'd30720, depth_scale: 16'd4096, segment_address: 32'h0};
    blend_color = '0;
    alpha_step = '0;
    alpha_sum = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_rows();
    test_points();
    test_random(300);
    test_views();
    drain();
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
